>>> sv/mbps_pkg.sv
// shared types and constants for the masked byte pattern search
// no dependencies; every other file of the block uses this package

package mbps_pkg;

	localparam int MAX_PATTERN_DEF = 16;
	localparam int OFFSET_BITS_DEF = 32;

	localparam int BYTE_W      = 8;
	localparam int CFG_WORD_W  = 64;
	localparam int CFG_IDX_W   = 3;
	localparam int LEN_REG_W   = 5;
	localparam int RES_OFS_W   = 32;
	localparam int LANES_MAX   = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LOW    = 3'd0,
		REG_PATTERN_HIGH   = 3'd1,
		REG_MASK_LOW       = 3'd2,
		REG_MASK_HIGH      = 3'd3,
		REG_PATTERN_LENGTH = 3'd4
	} cfg_reg_t;

endpackage

>>> sv/mbps_in_if.sv
// input byte channel of the masked byte pattern search
// depends on mbps_pkg

interface mbps_in_if;
	logic                        valid;
	logic                        ready;
	logic [mbps_pkg::BYTE_W-1:0] data_byte;
	logic                        last_of_region;

	modport source (output valid, output data_byte, output last_of_region, input ready);
	modport sink (input valid, input data_byte, input last_of_region, output ready);
endinterface

>>> sv/mbps_res_if.sv
// result channel of the masked byte pattern search
// depends on mbps_pkg

interface mbps_res_if;
	logic                           valid;
	logic                           ready;
	logic                           found;
	logic [mbps_pkg::RES_OFS_W-1:0] match_offset;

	modport source (output valid, output found, output match_offset, input ready);
	modport sink (input valid, input found, input match_offset, output ready);
endinterface

>>> sv/mbps_cfg_if.sv
// register write channel of the masked byte pattern search
// depends on mbps_pkg

interface mbps_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [mbps_pkg::CFG_IDX_W-1:0]  index;
	logic [mbps_pkg::CFG_WORD_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/mbps_cell.sv
// one window cell: holds one byte of the sliding window, passes it on each
// transfer and compares the byte it loads against its pattern lane; uses mbps_pkg

module mbps_cell #(
	parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF,
	parameter int POS         = 0
) (
	input  logic                                               clk,
	input  logic                                               shift_en,
	input  logic [mbps_pkg::BYTE_W-1:0]                        byte_in,
	input  logic [$clog2(MAX_PATTERN+1)-1:0]                   act_len,
	input  logic [MAX_PATTERN-1:0][mbps_pkg::BYTE_W-1:0]       pat_bytes,
	input  logic [MAX_PATTERN-1:0][mbps_pkg::BYTE_W-1:0]       mask_bytes,
	output logic [mbps_pkg::BYTE_W-1:0]                        byte_q,
	output logic                                               hit
);
	import mbps_pkg::*;

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);
	localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	logic             in_use;
	logic [IDX_W-1:0] lane;

	// window position POS lines up with pattern lane len-1-POS
	assign in_use = act_len > LEN_W'(POS);
	assign lane   = IDX_W'(act_len - LEN_W'(POS) - LEN_W'(1));
	assign hit    = !in_use || ((byte_in & mask_bytes[lane]) == pat_bytes[lane]);

	always_ff @(posedge clk) begin
		if (shift_en) begin
			byte_q <= byte_in;
		end
	end

endmodule

>>> sv/masked_byte_pattern_search.sv
// top level of the masked byte pattern search: register file, chain of window
// cells, region counter and result register; uses mbps_pkg, the three
// channel interfaces and mbps_cell
//
// usage:
//   cfg carries register writes (index, data): pattern low/high, mask low/high,
//   pattern length; cfg.ready is always high, writes land at the next edge
//   src carries one region byte per transfer, last_of_region marks its end
//   res carries one result (found, match_offset) per region, taken on the
//   transfer of the region's last byte
// timing:
//   one byte per cycle while no waiting result stalls src; the window is a row of
//   MAX_PATTERN cells that shift on each transfer while every cell does its masked
//   compare in the same cycle
//   the result is registered and appears on res in the cycle after the last byte's transfer
// stalls:
//   a result sits in the output register until res.ready; while it waits
//   src.ready follows res.ready, so bytes keep flowing when the sink takes it
// reset:
//   arst_n clears the counter, the found flag, the first offset and the result register;
//   registers return to zero, pattern length to one

module masked_byte_pattern_search #(
	parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF,
	parameter int OFFSET_BITS = mbps_pkg::OFFSET_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	mbps_in_if.sink    src,
	mbps_res_if.source res,
	mbps_cfg_if.sink   cfg
);
	import mbps_pkg::*;

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);

	logic [CFG_WORD_W-1:0] pattern_low_q;
	logic [CFG_WORD_W-1:0] pattern_high_q;
	logic [CFG_WORD_W-1:0] mask_low_q;
	logic [CFG_WORD_W-1:0] mask_high_q;
	logic [LEN_REG_W-1:0]  pattern_length_q;

	logic [2*CFG_WORD_W-1:0]              pat_all;
	logic [2*CFG_WORD_W-1:0]              mask_all;
	logic [MAX_PATTERN-1:0][BYTE_W-1:0]   pat_bytes;
	logic [MAX_PATTERN-1:0][BYTE_W-1:0]   mask_bytes;
	logic [MAX_PATTERN-1:0][BYTE_W-1:0]   win;
	logic [MAX_PATTERN-1:0]               hits;
	logic [LEN_W-1:0]                     act_len;

	logic                   accept;
	logic [OFFSET_BITS-1:0] count_q;
	logic [OFFSET_BITS-1:0] count_next;
	logic                   match_seen_q;
	logic                   match_seen_next;
	logic [OFFSET_BITS-1:0] first_offset_q;
	logic [OFFSET_BITS-1:0] first_offset_next;
	logic                   new_match;
	logic [63:0]            offset_ext;

	logic                   res_valid_q;
	logic                   found_q;
	logic [RES_OFS_W-1:0]   match_offset_q;

	// register file
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q    <= '0;
			pattern_high_q   <= '0;
			mask_low_q       <= '0;
			mask_high_q      <= '0;
			pattern_length_q <= LEN_REG_W'(1);
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_PATTERN_LOW:    pattern_low_q    <= cfg.data;
				REG_PATTERN_HIGH:   pattern_high_q   <= cfg.data;
				REG_MASK_LOW:       mask_low_q       <= cfg.data;
				REG_MASK_HIGH:      mask_high_q      <= cfg.data;
				REG_PATTERN_LENGTH: pattern_length_q <= cfg.data[LEN_REG_W-1:0];
				default: ;
			endcase
		end
	end

	assign pat_all  = {pattern_high_q, pattern_low_q};
	assign mask_all = {mask_high_q, mask_low_q};

	always_comb begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			pat_bytes[i]  = pat_all[BYTE_W*i +: BYTE_W];
			mask_bytes[i] = mask_all[BYTE_W*i +: BYTE_W];
		end
	end

	// zero length counts as one, anything above the window as a full window
	always_comb begin
		if (pattern_length_q == '0) begin
			act_len = LEN_W'(1);
		end else if (pattern_length_q > LEN_REG_W'(MAX_PATTERN)) begin
			act_len = LEN_W'(MAX_PATTERN);
		end else begin
			act_len = LEN_W'(pattern_length_q);
		end
	end

	// window cells, cell 0 holds the newest byte
	assign src.ready = !res_valid_q || res.ready;
	assign accept    = src.valid && src.ready;

	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
		logic [BYTE_W-1:0] cell_in;
		if (k == 0) begin : g_head
			assign cell_in = src.data_byte;
		end else begin : g_link
			assign cell_in = win[k-1];
		end
		mbps_cell #(
			.MAX_PATTERN (MAX_PATTERN),
			.POS         (k)
		) u_cell (
			.clk        (clk),
			.shift_en   (accept),
			.byte_in    (cell_in),
			.act_len    (act_len),
			.pat_bytes  (pat_bytes),
			.mask_bytes (mask_bytes),
			.byte_q     (win[k]),
			.hit        (hits[k])
		);
	end

	// region tracking
	always_comb begin
		count_next        = (count_q == '1) ? count_q : count_q + OFFSET_BITS'(1);
		new_match         = !match_seen_q && (count_next >= OFFSET_BITS'(act_len)) && (&hits);
		match_seen_next   = match_seen_q || new_match;
		first_offset_next = new_match ? count_next - OFFSET_BITS'(act_len) : first_offset_q;
		offset_ext        = 64'(first_offset_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			match_seen_q   <= 1'b0;
			first_offset_q <= '0;
		end else if (accept) begin
			if (src.last_of_region) begin
				count_q        <= '0;
				match_seen_q   <= 1'b0;
				first_offset_q <= '0;
			end else begin
				count_q        <= count_next;
				match_seen_q   <= match_seen_next;
				first_offset_q <= first_offset_next;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q    <= 1'b0;
			found_q        <= 1'b0;
			match_offset_q <= '0;
		end else if (accept && src.last_of_region) begin
			res_valid_q    <= 1'b1;
			found_q        <= match_seen_next;
			match_offset_q <= match_seen_next ? offset_ext[RES_OFS_W-1:0] : '0;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.found        = found_q;
	assign res.match_offset = match_offset_q;

`ifndef SYNTHESIS
	a_no_offset_without_match: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.found |-> res.match_offset == '0)
		else $error("offset reported without a match");

	a_stall_only_on_full_output: assert property (@(posedge clk) disable iff (!arst_n)
		!src.ready |-> res_valid_q && !res.ready)
		else $error("input stalled with a free result register");

	a_region_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && src.last_of_region |=> count_q == '0 && !match_seen_q && res_valid_q)
		else $error("region state not cleared at region end");

	a_count_steps: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !src.last_of_region && count_q != '1 |=> count_q == $past(count_q) + 1'b1)
		else $error("byte counter did not advance");

	a_first_match_holds: assert property (@(posedge clk) disable iff (!arst_n)
		match_seen_q && !(accept && src.last_of_region) |=>
			match_seen_q && $stable(first_offset_q))
		else $error("first match offset changed within a region");
`endif

endmodule
